/* hdl/tor_pkg.sv */
// shared types, byte codes and reply tables for the telnet option responder
`default_nettype none
package tor_pkg;

   // telnet command bytes
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;

   // option codes
   localparam logic [7:0] OPT_ECHO    = 8'd1;
   localparam logic [7:0] OPT_STATUS  = 8'd5;
   localparam logic [7:0] OPT_TTYPE   = 8'd24;
   localparam logic [7:0] OPT_NAWS    = 8'd31;
   localparam logic [7:0] OPT_AUTH    = 8'd37;
   localparam logic [7:0] OPT_ENCRYPT = 8'd38;

   // zmodem start pattern bytes
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_CAN  = 8'h18;
   localparam logic [7:0] CH_B    = 8'h42;
   localparam logic [7:0] CH_ZERO = 8'h30;

   localparam int unsigned CNT_W = 4;
   localparam logic [CNT_W-1:0] START_COUNT = 4'd15;

   // result kinds
   localparam logic [1:0] KIND_DISPLAY = 2'd0;
   localparam logic [1:0] KIND_SEND    = 2'd1;
   localparam logic [1:0] KIND_START   = 2'd2;

   // step counter over the results of one job (at most 11)
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] TTYPE_LEN = 4'd11;
   localparam logic [STEP_W-1:0] REPLY_LEN = 4'd3;
   localparam logic [STEP_W-1:0] OFFER_LEN = 4'd6;

   // one queued job: a plain byte or an option reply
   typedef struct packed {
      logic       is_option;
      logic       start_evt;   // plain: start event before display
      logic       show;        // plain: display the byte
      logic       reply;       // option: three-byte refusal
      logic       reply_wont;  // option: refusal verb is WONT, else DONT
      logic       offer;       // option: WILL NAWS and WILL TTYPE offer
      logic       ttype;       // option: terminal-type subnegotiation
      logic [7:0] data;        // plain byte or option code
   } job_type;

   // terminal-type reply: IAC SB TTYPE IS "vt100" IAC SE
   function automatic logic [7:0] ttype_byte(input logic [STEP_W-1:0] idx);
      logic [7:0] b;
      begin
         case (idx)
            4'd0:    b = B_IAC;
            4'd1:    b = B_SB;
            4'd2:    b = OPT_TTYPE;
            4'd3:    b = 8'd0;
            4'd4:    b = 8'h76;
            4'd5:    b = 8'h74;
            4'd6:    b = 8'h31;
            4'd7:    b = 8'h30;
            4'd8:    b = 8'h30;
            4'd9:    b = B_IAC;
            4'd10:   b = B_SE;
            default: b = 8'd0;
         endcase
         return b;
      end
   endfunction

   // option offer: IAC WILL NAWS IAC WILL TTYPE
   function automatic logic [7:0] offer_byte(input logic [2:0] idx);
      logic [7:0] b;
      begin
         case (idx)
            3'd0:    b = B_IAC;
            3'd1:    b = B_WILL;
            3'd2:    b = OPT_NAWS;
            3'd3:    b = B_IAC;
            3'd4:    b = B_WILL;
            3'd5:    b = OPT_TTYPE;
            default: b = 8'd0;
         endcase
         return b;
      end
   endfunction

endpackage
`default_nettype wire

/* hdl/telnet_option_responder_core.sv */
// top level of the telnet option responder with zmodem start detection
//
// Input channel req_*: one received byte per transaction (req_rx_byte).
// Result channel rsp_*: kind (display, send to remote, start receive), a
// data byte and a flag on the last result caused by an input byte.
// Both channels use valid/stall; a transaction moves when valid is high
// and stall is low. csr_wr_en writes csr_wr_data into the auto-detect
// enable bit (reset value 1); with it clear bytes are taken and dropped.
// The front part takes one byte per cycle while req_stall is low and
// pushes a job for each byte with results into a queue of QUEUE_DEPTH
// entries; req_stall is high only while that queue is full.
// The back part emits one result per cycle from the queue head while
// rsp_stall allows, through an output register: the first result of a
// byte passes through the queue and then the output register to rsp_*.
// A plain byte gives at most one result, so plain bytes keep one byte
// per cycle; the byte that completes the zmodem pattern gives a start
// result and, with display on, a display result. An option reply gives
// 3 results for a refusal, up to 9 with the offer, 11 for terminal-type.
// While rsp_stall is high the output register holds and the queue fills.
// Synchronous reset empties the queue and returns all negotiation state
// to idle with display enabled.
`default_nettype none
module telnet_option_responder_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_last_of_run,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);
   import tor_pkg::*;

   logic    auto_detect_enable_ff;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   job_type push_job;
   job_type head_job;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_detect_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         auto_detect_enable_ff <= csr_wr_data;
      end
   end

   // byte parser
   tor_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (auto_detect_enable_ff),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue
   tor_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // result sequencer
   tor_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .head_valid      (!queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire

/* hdl/tor_front.sv */
// front part: accepts received bytes, tracks negotiation state, builds jobs
`default_nettype none
module tor_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            enable,
   input  wire logic            req_valid,
   input  wire logic [7:0]      req_rx_byte,
   output logic                 req_stall,
   input  wire logic            queue_full,
   output logic                 push,
   output tor_pkg::job_type     push_job
);
   import tor_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_VERB   = 2'd1,
      PH_OPTION = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic             verb_dont_ff, verb_dont_in;
   logic             verb_do_ff, verb_do_in;
   logic             verb_will_ff, verb_will_in;
   logic             sub_seen_ff, sub_seen_in;
   logic             show_ff, show_in;
   logic             offer_sent_ff, offer_sent_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] zero_cnt;
   logic             accept;
   logic             has_result;
   job_type          job;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // count step for a '0' byte of the start pattern
   assign zero_cnt = (count_ff > 4'd3 && count_ff < START_COUNT) ? count_ff + 4'd1 : count_ff;

   // classify the byte and work out next state and the job
   always_comb begin
      phase_in      = phase_ff;
      verb_dont_in  = verb_dont_ff;
      verb_do_in    = verb_do_ff;
      verb_will_in  = verb_will_ff;
      sub_seen_in   = sub_seen_ff;
      show_in       = show_ff;
      offer_sent_in = offer_sent_ff;
      count_in      = count_ff;
      job           = '0;
      job.data      = req_rx_byte;
      has_result    = 1'b0;
      unique case (phase_ff)
         PH_VERB: begin
            verb_dont_in = (req_rx_byte == B_DONT);
            verb_will_in = (req_rx_byte == B_WILL);
            verb_do_in   = (req_rx_byte == B_DO);
            if (req_rx_byte == B_SB) begin
               sub_seen_in = 1'b1;
            end
            phase_in = PH_OPTION;
         end
         PH_OPTION: begin
            phase_in      = PH_IDLE;
            show_in       = 1'b1;
            job.is_option = 1'b1;
            case (req_rx_byte) inside
               OPT_ECHO: begin
                  if (verb_dont_ff && !verb_do_ff && !verb_will_ff) begin
                     show_in = 1'b0;
                  end
                  job.reply      = verb_do_ff;
                  job.reply_wont = 1'b1;
               end
               OPT_AUTH, OPT_ENCRYPT: begin
                  job.reply      = verb_do_ff || verb_will_ff;
                  job.reply_wont = verb_do_ff;
               end
               OPT_STATUS: begin
                  job.reply      = verb_will_ff || verb_do_ff || verb_dont_ff;
                  job.reply_wont = verb_will_ff || verb_do_ff;
               end
               OPT_NAWS: begin
               end
               OPT_TTYPE: begin
                  job.ttype = offer_sent_ff && sub_seen_ff;
               end
               default: begin
                  job.reply      = verb_will_ff || verb_do_ff;
                  job.reply_wont = verb_do_ff;
                  job.offer      = !offer_sent_ff;
                  offer_sent_in  = 1'b1;
               end
            endcase
            has_result = job.reply || job.offer || job.ttype;
         end
         default: begin
            case (req_rx_byte)
               B_IAC: begin
                  phase_in = PH_VERB;
                  show_in  = 1'b0;
                  count_in = '0;
               end
               CH_STAR: count_in = (count_ff <= 4'd1) ? count_ff + 4'd1 : '0;
               CH_CAN:  count_in = (count_ff == 4'd2) ? 4'd3 : '0;
               CH_B:    count_in = (count_ff == 4'd3) ? 4'd4 : '0;
               CH_ZERO: begin
                  if (zero_cnt == START_COUNT) begin
                     job.start_evt = 1'b1;
                     count_in      = '0;
                  end else begin
                     count_in = zero_cnt;
                  end
               end
               default: begin
               end
            endcase
            job.show   = show_in;
            has_result = job.show || job.start_evt;
         end
      endcase
   end

   assign push     = accept && enable && has_result;
   assign push_job = job;

   // negotiation state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         verb_dont_ff  <= 1'b0;
         verb_do_ff    <= 1'b0;
         verb_will_ff  <= 1'b0;
         sub_seen_ff   <= 1'b0;
         show_ff       <= 1'b1;
         offer_sent_ff <= 1'b0;
         count_ff      <= '0;
      end else if (accept && enable) begin
         phase_ff      <= phase_in;
         verb_dont_ff  <= verb_dont_in;
         verb_do_ff    <= verb_do_in;
         verb_will_ff  <= verb_will_in;
         sub_seen_ff   <= sub_seen_in;
         show_ff       <= show_in;
         offer_sent_ff <= offer_sent_in;
         count_ff      <= count_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/tor_queue.sv */
// job queue between front and back parts
`default_nettype none
module tor_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tor_pkg::job_type push_job,
   input  wire logic             pop,
   output tor_pkg::job_type      head_job,
   output logic                  full,
   output logic                  empty
);
   import tor_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   job_type        store_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   // no overflow, no underflow, count in range
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("job popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT) else $error("queue count out of range");

endmodule
`default_nettype wire

/* hdl/tor_back.sv */
// back part: expands queued jobs into result transactions
`default_nettype none
module tor_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tor_pkg::job_type head_job,
   input  wire logic             head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last_of_run
);
   import tor_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] n_items;
   logic [2:0]        offer_idx;
   logic              valid_ff;
   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        data_ff, data_in;
   logic              last_ff, last_in;
   logic              load;

   // number of results in the head job
   always_comb begin
      if (!head_job.is_option) begin
         n_items = STEP_W'(head_job.start_evt) + STEP_W'(head_job.show);
      end else if (head_job.ttype) begin
         n_items = TTYPE_LEN;
      end else begin
         n_items = (head_job.reply ? REPLY_LEN : '0) + (head_job.offer ? OFFER_LEN : '0);
      end
   end

   // offer position, wraps within three bits
   assign offer_idx = step_ff[2:0] - (head_job.reply ? REPLY_LEN[2:0] : 3'd0);

   // result at the current step
   always_comb begin
      kind_in = KIND_SEND;
      data_in = head_job.data;
      last_in = (step_ff == n_items - 1'b1);
      if (!head_job.is_option) begin
         if (head_job.start_evt && step_ff == '0) begin
            kind_in = KIND_START;
            data_in = 8'd0;
         end else begin
            kind_in = KIND_DISPLAY;
         end
      end else if (head_job.ttype) begin
         data_in = ttype_byte(step_ff);
      end else if (head_job.reply && step_ff < REPLY_LEN) begin
         case (step_ff[1:0])
            2'd0:    data_in = B_IAC;
            2'd1:    data_in = head_job.reply_wont ? B_WONT : B_DONT;
            default: data_in = head_job.data;
         endcase
      end else begin
         data_in = offer_byte(offer_idx);
      end
   end

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign pop     = load && last_in;
   assign step_in = last_in ? '0 : step_ff + 1'b1;

   // step counter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (load) begin
         step_ff  <= step_in;
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_last_of_run = last_ff;

endmodule
`default_nettype wire
